>>> rtl/core/lwfs_pkg.sv
// ----------------------------------------------------------------------------
// lwfs_pkg
// Shared types, codes and helpers for the panel window-fill sequencer.
// ----------------------------------------------------------------------------
package lwfs_pkg;

	// default and widest coordinate width
	localparam int COORD_BITS_DEF = 10;
	localparam int COORD_BITS_MAX = 16;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration channel
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_WAIT   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SLEEP_WAIT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_FORMAT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ORIENTATION  = 3'd4;

	// register reset values
	localparam logic [7:0] RESET_LOW_DEF    = 8'd150;
	localparam logic [7:0] RESET_WAIT_DEF   = 8'd50;
	localparam logic [7:0] SLEEP_WAIT_DEF   = 8'd100;
	localparam logic [7:0] PIXEL_FORMAT_DEF = 8'h55;
	localparam logic [7:0] ORIENTATION_DEF  = 8'h00;

	// request selector on the input stream
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_FILL = 2'd1;
	localparam logic [1:0] FUNC_INIT = 2'd2;

	// panel commands
	localparam logic [7:0] CMD_SLPOUT = 8'h11;
	localparam logic [7:0] CMD_COLMOD = 8'h3A;
	localparam logic [7:0] CMD_MADCTL = 8'h36;
	localparam logic [7:0] CMD_INVON  = 8'h21;
	localparam logic [7:0] CMD_DISPON = 8'h29;
	localparam logic [7:0] CMD_CASET  = 8'h2A;
	localparam logic [7:0] CMD_RASET  = 8'h2B;
	localparam logic [7:0] CMD_RAMWR  = 8'h2C;

	// request status codes
	localparam logic [1:0] ST_NONE       = 2'd0;
	localparam logic [1:0] ST_ACCEPT     = 2'd1;
	localparam logic [1:0] ST_BUSY       = 2'd2;
	localparam logic [1:0] ST_BAD_WINDOW = 2'd3;

	// init sequence steps
	localparam logic [3:0] INIT_RST_LOW    = 4'd0;
	localparam logic [3:0] INIT_RST_WAIT   = 4'd1;
	localparam logic [3:0] INIT_SLP_OUT    = 4'd2;
	localparam logic [3:0] INIT_SLP_WAIT   = 4'd3;
	localparam logic [3:0] INIT_COLMOD     = 4'd4;
	localparam logic [3:0] INIT_COLMOD_ARG = 4'd5;
	localparam logic [3:0] INIT_MADCTL     = 4'd6;
	localparam logic [3:0] INIT_MADCTL_ARG = 4'd7;
	localparam logic [3:0] INIT_INVON      = 4'd8;
	localparam logic [3:0] INIT_DISPON     = 4'd9;

	// fill sequence steps
	localparam logic [3:0] FILL_CASET   = 4'd0;
	localparam logic [3:0] FILL_XS_HI   = 4'd1;
	localparam logic [3:0] FILL_XS_LO   = 4'd2;
	localparam logic [3:0] FILL_XE_HI   = 4'd3;
	localparam logic [3:0] FILL_XE_LO   = 4'd4;
	localparam logic [3:0] FILL_RASET   = 4'd5;
	localparam logic [3:0] FILL_YS_HI   = 4'd6;
	localparam logic [3:0] FILL_YS_LO   = 4'd7;
	localparam logic [3:0] FILL_YE_HI   = 4'd8;
	localparam logic [3:0] FILL_YE_LO   = 4'd9;
	localparam logic [3:0] FILL_RAMWR   = 4'd10;
	localparam logic [3:0] FILL_PIXELS  = 4'd11;

	// classified request kind
	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_FILL,
		KIND_INIT,
		KIND_NOP
	} kind_t;

	// sequencer mode
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INIT,
		MODE_FILL
	} mode_t;

	// one result item
	typedef struct packed {
		logic       byte_valid;
		logic       dc_level;
		logic [7:0] data_byte;
		logic       reset_level;
		logic       busy_res;
		logic       last_byte;
		logic [1:0] status;
	} res_t;

	// bits of one queued entry: kind, bad flag, four corners, two spans, color
	function automatic int entry_bits(input int cb);
		return 2 + 1 + 6 * cb + 16;
	endfunction

	// a wait register of zero counts as one tick
	function automatic logic [7:0] at_least_one(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

endpackage

>>> rtl/core/lwfs_front.sv
// ----------------------------------------------------------------------------
// lwfs_front
// Accepts requests, classifies them and checks the window, one stage deep.
// ----------------------------------------------------------------------------
module lwfs_front #(
	parameter int COORD_BITS = lwfs_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W    = lwfs_pkg::entry_bits(lwfs_pkg::COORD_BITS_DEF)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [15:0]           fill_color,
	output logic                  entry_valid,
	input  logic                  entry_ready,
	output logic [ENTRY_W-1:0]    entry
);
	import lwfs_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic                  bad;
		logic [COORD_BITS-1:0] x_lo;
		logic [COORD_BITS-1:0] x_hi;
		logic [COORD_BITS-1:0] y_lo;
		logic [COORD_BITS-1:0] y_hi;
		logic [COORD_BITS-1:0] span_x;
		logic [COORD_BITS-1:0] span_y;
		logic [15:0]           color;
	} entry_t;

	entry_t              cls;
	entry_t              entry_s1;
	logic                valid_s1;
	logic [COORD_BITS:0] diff_x;
	logic [COORD_BITS:0] diff_y;

	// window spans; a borrow means end before start
	assign diff_x = {1'b0, x_end} - {1'b0, x_start};
	assign diff_y = {1'b0, y_end} - {1'b0, y_start};

	// classify the request
	always_comb begin
		cls.kind   = KIND_NOP;
		cls.bad    = diff_x[COORD_BITS] | diff_y[COORD_BITS];
		cls.x_lo   = x_start;
		cls.x_hi   = x_end;
		cls.y_lo   = y_start;
		cls.y_hi   = y_end;
		cls.span_x = diff_x[COORD_BITS-1:0];
		cls.span_y = diff_y[COORD_BITS-1:0];
		cls.color  = fill_color;
		case (func)
			FUNC_TICK: cls.kind = KIND_TICK;
			FUNC_FILL: cls.kind = KIND_FILL;
			FUNC_INIT: cls.kind = KIND_INIT;
			default:   cls.kind = KIND_NOP;
		endcase
	end

	assign in_ready = !valid_s1 || entry_ready;

	// stage register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= cls;
		end
	end

	assign entry_valid = valid_s1;
	assign entry       = entry_s1;

endmodule

>>> rtl/core/lwfs_queue.sv
// ----------------------------------------------------------------------------
// lwfs_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module lwfs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lwfs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/lwfs_back.sv
// ----------------------------------------------------------------------------
// lwfs_back
// Runs init and fill sequences into an output register, one queued request
// per cycle while it is not stalled; also holds the configuration registers.
// ----------------------------------------------------------------------------
module lwfs_back #(
	parameter int COORD_BITS = lwfs_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W    = lwfs_pkg::entry_bits(lwfs_pkg::COORD_BITS_DEF)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lwfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic                                q_valid,
	input  logic [ENTRY_W-1:0]                  q_data,
	output logic                                q_pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output lwfs_pkg::res_t                      res
);
	import lwfs_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic                  bad;
		logic [COORD_BITS-1:0] x_lo;
		logic [COORD_BITS-1:0] x_hi;
		logic [COORD_BITS-1:0] y_lo;
		logic [COORD_BITS-1:0] y_hi;
		logic [COORD_BITS-1:0] span_x;
		logic [COORD_BITS-1:0] span_y;
		logic [15:0]           color;
	} entry_t;

	entry_t e;

	// configuration registers
	logic [7:0] reset_low_q, reset_wait_q, sleep_wait_q, pix_fmt_q, orient_q;

	// sequencer state
	mode_t                 mode_q, mode_d;
	logic [3:0]            step_q, step_d;
	logic [7:0]            wait_q, wait_d;
	logic                  rst_line_q, rst_line_d;
	logic                  low_half_q, low_half_d;
	logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
	logic [COORD_BITS-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q, span_x_q, span_y_q;
	logic [15:0]           color_q;
	logic                  load_window;
	logic [7:0]            wait_dec;
	logic [15:0]           xs_w, xe_w, ys_w, ye_w;
	logic                  col_end, row_end;

	res_t res_d;
	res_t res_q;
	logic res_valid_q;

	assign e        = entry_t'(q_data);
	assign q_pop    = q_valid && (!res_valid_q || res_ready);
	assign wait_dec = wait_q - 8'd1;
	assign xs_w     = 16'(x_lo_q);
	assign xe_w     = 16'(x_hi_q);
	assign ys_w     = 16'(y_lo_q);
	assign ye_w     = 16'(y_hi_q);
	assign col_end  = col_q == span_x_q;
	assign row_end  = row_q == span_y_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q  <= RESET_LOW_DEF;
			reset_wait_q <= RESET_WAIT_DEF;
			sleep_wait_q <= SLEEP_WAIT_DEF;
			pix_fmt_q    <= PIXEL_FORMAT_DEF;
			orient_q     <= ORIENTATION_DEF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RESET_LOW:    reset_low_q  <= cfg_data;
				REG_RESET_WAIT:   reset_wait_q <= cfg_data;
				REG_SLEEP_WAIT:   sleep_wait_q <= cfg_data;
				REG_PIXEL_FORMAT: pix_fmt_q    <= cfg_data;
				REG_ORIENTATION:  orient_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		mode_d      = mode_q;
		step_d      = step_q;
		wait_d      = wait_q;
		rst_line_d  = rst_line_q;
		low_half_d  = low_half_q;
		col_d       = col_q;
		row_d       = row_q;
		load_window = 1'b0;
		case (e.kind)
			KIND_INIT: begin
				if (mode_q == MODE_IDLE) begin
					mode_d     = MODE_INIT;
					step_d     = INIT_RST_LOW;
					rst_line_d = 1'b0;
					wait_d     = at_least_one(reset_low_q);
				end
			end
			KIND_FILL: begin
				if (mode_q == MODE_IDLE && !e.bad) begin
					mode_d      = MODE_FILL;
					step_d      = FILL_CASET;
					load_window = 1'b1;
					col_d       = '0;
					row_d       = '0;
					low_half_d  = 1'b0;
				end
			end
			KIND_TICK: begin
				case (mode_q)
					MODE_INIT: begin
						case (step_q)
							INIT_RST_LOW: begin
								wait_d = wait_dec;
								if (wait_dec == 8'd0) begin
									rst_line_d = 1'b1;
									wait_d     = at_least_one(reset_wait_q);
									step_d     = INIT_RST_WAIT;
								end
							end
							INIT_RST_WAIT, INIT_SLP_WAIT: begin
								wait_d = wait_dec;
								if (wait_dec == 8'd0) begin
									step_d = step_q + 4'd1;
								end
							end
							INIT_SLP_OUT: begin
								wait_d = at_least_one(sleep_wait_q);
								step_d = INIT_SLP_WAIT;
							end
							INIT_COLMOD, INIT_COLMOD_ARG, INIT_MADCTL,
							INIT_MADCTL_ARG, INIT_INVON: begin
								step_d = step_q + 4'd1;
							end
							default: begin
								mode_d = MODE_IDLE;
								step_d = INIT_RST_LOW;
							end
						endcase
					end
					MODE_FILL: begin
						if (step_q < FILL_PIXELS) begin
							step_d = step_q + 4'd1;
						end else if (!low_half_q) begin
							low_half_d = 1'b1;
						end else begin
							low_half_d = 1'b0;
							if (col_end) begin
								col_d = '0;
								if (row_end) begin
									mode_d = MODE_IDLE;
									step_d = FILL_CASET;
									row_d  = '0;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		res_d             = '0;
		res_d.reset_level = rst_line_d;
		res_d.busy_res    = mode_d != MODE_IDLE;
		case (e.kind)
			KIND_INIT, KIND_FILL: begin
				if (mode_q != MODE_IDLE) begin
					res_d.status = ST_BUSY;
				end else if (e.kind == KIND_FILL && e.bad) begin
					res_d.status = ST_BAD_WINDOW;
				end else begin
					res_d.status = ST_ACCEPT;
				end
			end
			KIND_TICK: begin
				case (mode_q)
					MODE_INIT: begin
						res_d.byte_valid = 1'b1;
						case (step_q)
							INIT_RST_LOW, INIT_RST_WAIT, INIT_SLP_WAIT:
								res_d.byte_valid = 1'b0;
							INIT_SLP_OUT:    res_d.data_byte = CMD_SLPOUT;
							INIT_COLMOD:     res_d.data_byte = CMD_COLMOD;
							INIT_COLMOD_ARG: begin
								res_d.dc_level  = 1'b1;
								res_d.data_byte = pix_fmt_q;
							end
							INIT_MADCTL:     res_d.data_byte = CMD_MADCTL;
							INIT_MADCTL_ARG: begin
								res_d.dc_level  = 1'b1;
								res_d.data_byte = orient_q;
							end
							INIT_INVON:      res_d.data_byte = CMD_INVON;
							default: begin
								res_d.data_byte = CMD_DISPON;
								res_d.last_byte = 1'b1;
							end
						endcase
					end
					MODE_FILL: begin
						res_d.byte_valid = 1'b1;
						res_d.dc_level   = 1'b1;
						case (step_q)
							FILL_CASET: begin
								res_d.dc_level  = 1'b0;
								res_d.data_byte = CMD_CASET;
							end
							FILL_XS_HI: res_d.data_byte = xs_w[15:8];
							FILL_XS_LO: res_d.data_byte = xs_w[7:0];
							FILL_XE_HI: res_d.data_byte = xe_w[15:8];
							FILL_XE_LO: res_d.data_byte = xe_w[7:0];
							FILL_RASET: begin
								res_d.dc_level  = 1'b0;
								res_d.data_byte = CMD_RASET;
							end
							FILL_YS_HI: res_d.data_byte = ys_w[15:8];
							FILL_YS_LO: res_d.data_byte = ys_w[7:0];
							FILL_YE_HI: res_d.data_byte = ye_w[15:8];
							FILL_YE_LO: res_d.data_byte = ye_w[7:0];
							FILL_RAMWR: begin
								res_d.dc_level  = 1'b0;
								res_d.data_byte = CMD_RAMWR;
							end
							default: begin
								res_d.data_byte = low_half_q ? color_q[7:0] : color_q[15:8];
								res_d.last_byte = low_half_q && col_end && row_end;
							end
						endcase
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			step_q     <= '0;
			wait_q     <= '0;
			rst_line_q <= 1'b1;
			low_half_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (q_pop) begin
			mode_q     <= mode_d;
			step_q     <= step_d;
			wait_q     <= wait_d;
			rst_line_q <= rst_line_d;
			low_half_q <= low_half_d;
			col_q      <= col_d;
			row_q      <= row_d;
		end
	end

	// window and color captured on an accepted fill
	always_ff @(posedge clk) begin
		if (q_pop && load_window) begin
			x_lo_q   <= e.x_lo;
			x_hi_q   <= e.x_hi;
			y_lo_q   <= e.y_lo;
			y_hi_q   <= e.y_hi;
			span_x_q <= e.span_x;
			span_y_q <= e.span_y;
			color_q  <= e.color;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			res_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a request result never carries a panel byte
	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status != ST_NONE |-> !res_q.byte_valid)
		else $error("request result carries a byte");

	// the final byte of a sequence leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.last_byte |-> res_q.byte_valid && !res_q.busy_res)
		else $error("last byte while still busy");

	// the panel reset line is released whenever no sequence runs
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> rst_line_q)
		else $error("panel reset held while idle");

	// init never runs past display-on
	a_init_step: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_INIT |-> step_q <= INIT_DISPON)
		else $error("init step out of range");

	// pixel counters stay inside the window
	a_pixel_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_FILL |-> col_q <= span_x_q && row_q <= span_y_q)
		else $error("pixel counter outside window");

endmodule

>>> rtl/core/lcd_window_fill_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer
// Init and rectangle-fill byte sequencer for a serial TFT panel.
// ----------------------------------------------------------------------------
//
//   channel   signals                              role
//   s_axis    s_tvalid s_tready s_tdata s_tuser    requests and byte ticks in
//   m_axis    m_tvalid m_tready m_tdata m_tuser    one result per request out
//             m_tlast
//   cfg       cfg_valid cfg_ready cfg_index        register writes
//             cfg_data
//
// One transaction in gives one transaction out; a new one is taken every cycle
// while no side stalls, through front classify stage, queue, output register.
// The back sequencer step is the per-item loop and settles the rate.
// Either side may stall; the queue and output register keep full throughput.
// After reset the configuration registers hold their defaults, the panel
// reset line is released and the sequencer is idle.
// ----------------------------------------------------------------------------
module lcd_window_fill_sequencer #(
	parameter int  COORD_BITS  = lwfs_pkg::COORD_BITS_DEF,
	parameter int  QUEUE_DEPTH = lwfs_pkg::QUEUE_DEPTH_DEF,
	localparam int IN_W        = ((4 * COORD_BITS + 16 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// x_start, y_start, x_end, y_end, fill_color, zero fill
	input  logic [IN_W-1:0]                     s_tdata,
	// func
	input  logic [1:0]                          s_tuser,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// byte_valid, data_byte, reset_level, busy_res, status, zero fill
	output logic [15:0]                         m_tdata,
	// dc_level
	output logic                                m_tuser,
	output logic                                m_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lwfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [7:0]                          cfg_data
);
	import lwfs_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int ENTRY_W = entry_bits(COORD_BITS);

	logic               f_valid;
	logic               f_ready;
	logic [ENTRY_W-1:0] f_entry;
	logic               q_valid;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_data;
	res_t               res;

	assign cfg_ready = 1'b1;

	// request intake and classification
	lwfs_front #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.func        (s_tuser),
		.x_start     (s_tdata[CB-1:0]),
		.y_start     (s_tdata[2*CB-1:CB]),
		.x_end       (s_tdata[3*CB-1:2*CB]),
		.y_end       (s_tdata[4*CB-1:3*CB]),
		.fill_color  (s_tdata[4*CB+15:4*CB]),
		.entry_valid (f_valid),
		.entry_ready (f_ready),
		.entry       (f_entry)
	);

	// decoupling queue
	lwfs_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_entry),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	// sequencer
	lwfs_back #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// result packing
	assign m_tdata = {3'b000, res.status, res.busy_res, res.reset_level,
		res.data_byte, res.byte_valid};
	assign m_tuser = res.dc_level;
	assign m_tlast = res.last_byte;

endmodule
